// ===== sv/xpt_pkg.sv =====
`timescale 1ns / 1ps
// xpt_pkg: word types, opcodes and fixed constants of the pen trace capture unit
// no dependencies; used by xpt_offset_ram and xy_pen_trace_capture_unit

package xpt_pkg;

    // opcodes of an input word
    localparam logic [1:0] OP_SAMPLE    = 2'd0;
    localparam logic [1:0] OP_BLOCK_END = 2'd1;
    localparam logic [1:0] OP_ARM       = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_TRACE_POINTS  = 2'd0;
    localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd1;

    localparam int CFG_W     = 11;
    localparam int SAMPLE_W  = 16;
    localparam int OFFSET_W  = 11;
    localparam int COL_OUT_W = 10;
    localparam int VALUE_W   = 12;

    localparam logic [15:0] PEN_UP_THRESHOLD = 16'd32768;
    localparam logic [12:0] RETRACE_LIMIT    = 13'd5;
    localparam logic [10:0] TRACE_POINTS_RST  = 11'd1024;
    localparam logic [10:0] SCREEN_HEIGHT_RST = 11'd512;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [15:0] x_sample;
        logic [15:0] y_sample;
        logic [15:0] z_sample;
        logic [7:0]  arm_count;
    } sample_word_t;

    typedef struct packed {
        logic               write_valid;
        logic [9:0]         column;
        logic signed [11:0] trace_value;
        logic               normalizing;
    } trace_word_t;

endpackage

// ===== sv/xpt_offset_ram.sv =====
`timescale 1ns / 1ps
// xpt_offset_ram: per-column normalization offset memory with a clear sweep after reset
// depends on xpt_pkg for the offset width

module xpt_offset_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              rd_en,
    input  logic [AW-1:0]                     rd_addr,
    output logic [xpt_pkg::OFFSET_W-1:0]      rd_data,
    input  logic                              wr_en,
    input  logic [AW-1:0]                     wr_addr,
    input  logic [xpt_pkg::OFFSET_W-1:0]      wr_data,
    output logic                              busy
);

    logic [xpt_pkg::OFFSET_W-1:0] mem [DEPTH];
    logic [xpt_pkg::OFFSET_W-1:0] rd_data_reg;
    logic                         clr_busy_reg;
    logic                         clr_busy_next;
    logic [AW-1:0]                clr_addr_reg;
    logic [AW-1:0]                clr_addr_next;
    logic                         we;
    logic [AW-1:0]                wa;
    logic [xpt_pkg::OFFSET_W-1:0] wd;

    // clear sweep, one entry per cycle
    always_comb
    begin
        clr_busy_next = clr_busy_reg;
        clr_addr_next = clr_addr_reg;
        if (clr_busy_reg)
        begin
            if (clr_addr_reg == AW'(DEPTH - 1))
            begin
                clr_busy_next = 1'b0;
            end
            else
            begin
                clr_addr_next = clr_addr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else
        begin
            clr_busy_reg <= clr_busy_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    // write port shared by the sweep and the update path
    always_comb
    begin
        we = wr_en;
        wa = wr_addr;
        wd = wr_data;
        if (clr_busy_reg)
        begin
            we = 1'b1;
            wa = clr_addr_reg;
            wd = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
    assign busy    = clr_busy_reg;

endmodule

// ===== sv/xy_pen_trace_capture_unit.sv =====
`timescale 1ns / 1ps
// xy_pen_trace_capture_unit: top level, scales X/Y/Z triples and emits trace column writes
// depends on xpt_pkg and xpt_offset_ram
//
//  channel | direction | handshake             | word
//  --------+-----------+-----------------------+------------------------------------
//  sample  | in        | sample_valid / stall  | xpt_pkg::sample_word_t
//  trace   | out       | trace_valid / stall   | xpt_pkg::trace_word_t
//  cfg     | in        | cfg_valid / cfg_ready | cfg_index (register), cfg_data
//
//  One word per cycle while trace_stall is low. At acceptance the column is scaled and
//  the offset RAM is read; the work stage then does the read-modify-write and loads the
//  output register. A write to the same column by the word just ahead is forwarded
//  around the RAM. After reset a clear sweep of all MAX_POINTS entries runs with
//  sample_stall high. trace_stall holds the output register; one more word may enter.

module xy_pen_trace_capture_unit #(
    parameter int MAX_POINTS = 1024
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  sample_valid,
    output logic                  sample_stall,
    input  xpt_pkg::sample_word_t sample,
    output logic                  trace_valid,
    input  logic                  trace_stall,
    output xpt_pkg::trace_word_t  trace,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [1:0]            cfg_index,
    input  logic [10:0]           cfg_data
);

    localparam int CW = $clog2(MAX_POINTS);
    localparam logic [12:0] LAST_COL = 13'(MAX_POINTS - 1);

    // configuration registers
    logic [10:0] trace_points_reg;
    logic [10:0] screen_height_reg;

    // accept stage
    logic        accept;
    logic        ram_busy;
    logic [26:0] x_prod;
    logic [26:0] y_prod;
    logic [12:0] col_raw;
    logic [CW-1:0] col_a;

    // work stage registers
    logic          s1_valid_reg;
    logic [1:0]    s1_op_reg;
    logic [CW-1:0] s1_col_reg;
    logic [10:0]   s1_h_reg;
    logic          s1_pen_up_reg;
    logic [7:0]    s1_arm_reg;
    logic          fwd_hit_reg;
    logic [10:0]   fwd_data_reg;

    // architectural state
    logic [CW-1:0] last_col_reg;
    logic [CW-1:0] last_col_next;
    logic [7:0]    pending_reg;
    logic [7:0]    pending_next;

    // output register
    logic                 out_valid_reg;
    xpt_pkg::trace_word_t out_word_reg;
    xpt_pkg::trace_word_t out_word_next;

    logic          out_load;
    logic [10:0]   rd_data;
    logic [10:0]   cur_off;
    logic [10:0]   new_off;
    logic [10:0]   use_off;
    logic [CW-1:0] last_eff;
    logic          do_write;
    logic          mem_we;
    logic signed [12:0] sum;
    logic signed [11:0] tv;

    // configuration writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trace_points_reg  <= xpt_pkg::TRACE_POINTS_RST;
            screen_height_reg <= xpt_pkg::SCREEN_HEIGHT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                xpt_pkg::REG_TRACE_POINTS:  trace_points_reg  <= cfg_data;
                xpt_pkg::REG_SCREEN_HEIGHT: screen_height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // handshake
    assign out_load     = !out_valid_reg || !trace_stall;
    assign sample_stall = ram_busy || (s1_valid_reg && !out_load);
    assign accept       = sample_valid && !sample_stall;

    // column and height scaling
    assign x_prod  = 27'(sample.x_sample) * 27'(trace_points_reg);
    assign y_prod  = 27'(sample.y_sample) * 27'(screen_height_reg);
    assign col_raw = 13'(x_prod[26:16]);
    assign col_a   = (col_raw > LAST_COL) ? LAST_COL[CW-1:0] : col_raw[CW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            fwd_hit_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
                fwd_hit_reg  <= mem_we && (s1_col_reg == col_a);
            end
            else if (out_load)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_op_reg     <= sample.opcode;
            s1_col_reg    <= col_a;
            s1_h_reg      <= screen_height_reg - y_prod[26:16];
            s1_pen_up_reg <= sample.z_sample > xpt_pkg::PEN_UP_THRESHOLD;
            s1_arm_reg    <= sample.arm_count;
            fwd_data_reg  <= new_off;
        end
    end

    // offset memory
    xpt_offset_ram #(
        .DEPTH (MAX_POINTS),
        .AW    (CW)
    ) u_offset_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (col_a),
        .rd_data (rd_data),
        .wr_en   (mem_we),
        .wr_addr (s1_col_reg),
        .wr_data (new_off),
        .busy    (ram_busy)
    );

    // read-modify-write of the offset and state update
    assign cur_off  = fwd_hit_reg ? fwd_data_reg : rd_data;
    assign new_off  = 11'({1'b0, screen_height_reg[10:1]}) - s1_h_reg;
    assign last_eff = (13'(s1_col_reg) < xpt_pkg::RETRACE_LIMIT) ? '0 : last_col_reg;
    assign do_write = (s1_op_reg == xpt_pkg::OP_SAMPLE) && (s1_col_reg > last_eff)
                      && !s1_pen_up_reg;
    assign mem_we   = s1_valid_reg && out_load && do_write && (pending_reg != 8'd0);
    assign use_off  = (pending_reg != 8'd0) ? new_off : cur_off;
    assign sum      = $signed({2'b00, s1_h_reg}) + $signed({{2{use_off[10]}}, use_off});

    // saturate to the 12-bit result
    always_comb
    begin
        if (sum > 13'sd2047)
        begin
            tv = 12'sd2047;
        end
        else if (sum < -13'sd2048)
        begin
            tv = -12'sd2048;
        end
        else
        begin
            tv = sum[11:0];
        end
    end

    always_comb
    begin
        last_col_next = last_col_reg;
        pending_next  = pending_reg;
        unique case (s1_op_reg)
            xpt_pkg::OP_SAMPLE:
            begin
                last_col_next = do_write ? s1_col_reg : last_eff;
            end
            xpt_pkg::OP_BLOCK_END:
            begin
                if (pending_reg != 8'd0)
                begin
                    pending_next = pending_reg - 8'd1;
                end
            end
            xpt_pkg::OP_ARM:
            begin
                pending_next = s1_arm_reg;
            end
            default: ;
        endcase

        out_word_next.write_valid = do_write;
        out_word_next.column      = do_write ? xpt_pkg::COL_OUT_W'(s1_col_reg) : '0;
        out_word_next.trace_value = do_write ? tv : '0;
        out_word_next.normalizing = pending_next != 8'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_col_reg  <= '0;
            pending_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= s1_valid_reg;
            if (s1_valid_reg)
            begin
                last_col_reg <= last_col_next;
                pending_reg  <= pending_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load && s1_valid_reg)
        begin
            out_word_reg <= out_word_next;
        end
    end

    assign trace_valid = out_valid_reg;
    assign trace       = out_word_reg;

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// tb: self-checking bench for xy_pen_trace_capture_unit, directed table then random plotter sweeps
// depends on xpt_pkg and the unit's rtl; scores trace words against typed rows or a scaling model

module tb;

    localparam int MAX_POINTS  = 1024;
    localparam int N_PHASES    = 8;
    localparam int PHASE_WORDS = 183;
    localparam int DIR_ROWS    = 24;

    // opcodes and register indexes, short names for the stimulus table
    localparam logic [1:0] OP_SAMPLE         = xpt_pkg::OP_SAMPLE;
    localparam logic [1:0] OP_BLOCK_END      = xpt_pkg::OP_BLOCK_END;
    localparam logic [1:0] OP_ARM            = xpt_pkg::OP_ARM;
    localparam logic [1:0] REG_TRACE_POINTS  = xpt_pkg::REG_TRACE_POINTS;
    localparam logic [1:0] REG_SCREEN_HEIGHT = xpt_pkg::REG_SCREEN_HEIGHT;

    // codes the package does not name
    localparam logic [1:0] OP_UNUSED  = 2'd3;
    localparam logic [1:0] REG_UNUSED = 2'd3;

    logic                  clk;
    logic                  rst_n;
    logic                  sample_valid;
    logic                  sample_stall;
    xpt_pkg::sample_word_t sample;
    logic                  trace_valid;
    logic                  trace_stall;
    xpt_pkg::trace_word_t  trace;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [1:0]            cfg_index;
    logic [10:0]           cfg_data;

    // scaling model state
    logic [10:0]        tp_reg;
    logic [10:0]        sh_reg;
    logic [9:0]         last_col;
    logic [7:0]         blocks_left;
    logic signed [10:0] offset_store [MAX_POINTS];

    xpt_pkg::trace_word_t trace_q [$];
    int                   fault_count;
    int                   words_sent;
    bit                   burst_mode;

    // directed rows: word, whether the result is typed in, and that result
    typedef struct packed {
        xpt_pkg::sample_word_t word;
        bit                    typed;
        xpt_pkg::trace_word_t  fixed;
    } directed_row_t;

    directed_row_t directed_rows [DIR_ROWS] = '{
        // reset tracker at column zero, then full-scale x saturating to the last column
        '{'{OP_SAMPLE, 16'h0000, 16'h0000, 16'h0000, 8'h00}, 1'b1, '{1'b0, 10'd0, 12'sd0, 1'b0}},
        '{'{OP_SAMPLE, 16'hFFFF, 16'h0000, 16'h0000, 8'h00}, 1'b1, '{1'b1, 10'd1023, 12'sd512, 1'b0}},
        '{'{OP_SAMPLE, 16'hFFFF, 16'hFFFF, 16'h0000, 8'h00}, 1'b1, '{1'b0, 10'd0, 12'sd0, 1'b0}},
        // pen up, then pen exactly at threshold counts as down
        '{'{OP_SAMPLE, 16'h0000, 16'h0000, 16'hFFFF, 8'h00}, 1'b1, '{1'b0, 10'd0, 12'sd0, 1'b0}},
        '{'{OP_SAMPLE, 16'h8000, 16'hFFFF, 16'h8001, 8'h00}, 1'b1, '{1'b0, 10'd0, 12'sd0, 1'b0}},
        '{'{OP_SAMPLE, 16'h8000, 16'hFFFF, 16'h8000, 8'h00}, 1'b1, '{1'b1, 10'd512, 12'sd1, 1'b0}},
        // arm, unused opcode, armed writes record offsets
        '{'{OP_ARM, 16'h0000, 16'h0000, 16'h0000, 8'hFF}, 1'b1, '{1'b0, 10'd0, 12'sd0, 1'b1}},
        '{'{OP_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF}, 1'b1, '{1'b0, 10'd0, 12'sd0, 1'b1}},
        '{'{OP_SAMPLE, 16'h0000, 16'h0000, 16'h0000, 8'h00}, 1'b1, '{1'b0, 10'd0, 12'sd0, 1'b1}},
        '{'{OP_SAMPLE, 16'h4000, 16'h0000, 16'h0000, 8'h00}, 1'b1, '{1'b1, 10'd256, 12'sd256, 1'b1}},
        '{'{OP_SAMPLE, 16'h4400, 16'hFFFF, 16'h0000, 8'h00}, 1'b1, '{1'b1, 10'd272, 12'sd256, 1'b1}},
        '{'{OP_BLOCK_END, 16'h0000, 16'h0000, 16'h0000, 8'h00}, 1'b1, '{1'b0, 10'd0, 12'sd0, 1'b1}},
        '{'{OP_ARM, 16'h0000, 16'h0000, 16'h0000, 8'h00}, 1'b1, '{1'b0, 10'd0, 12'sd0, 1'b0}},
        // disarmed writes apply the stored offsets
        '{'{OP_SAMPLE, 16'h0000, 16'h0000, 16'h0000, 8'h00}, 1'b1, '{1'b0, 10'd0, 12'sd0, 1'b0}},
        '{'{OP_SAMPLE, 16'h4000, 16'hFFFF, 16'h0000, 8'h00}, 1'b1, '{1'b1, 10'd256, -12'sd255, 1'b0}},
        '{'{OP_SAMPLE, 16'h4400, 16'h0000, 16'h0000, 8'h00}, 1'b1, '{1'b1, 10'd272, 12'sd767, 1'b0}},
        // column 5 keeps the tracker, column 4 clears it
        '{'{OP_SAMPLE, 16'h0140, 16'h0000, 16'h0000, 8'h00}, 1'b1, '{1'b0, 10'd0, 12'sd0, 1'b0}},
        '{'{OP_SAMPLE, 16'h0100, 16'h0000, 16'h0000, 8'h00}, 1'b1, '{1'b1, 10'd4, 12'sd512, 1'b0}},
        '{'{OP_SAMPLE, 16'h0140, 16'h0000, 16'h0000, 8'h00}, 1'b1, '{1'b1, 10'd5, 12'sd512, 1'b0}},
        // block end with nothing pending, single-block arm
        '{'{OP_BLOCK_END, 16'h0000, 16'h0000, 16'h0000, 8'h00}, 1'b1, '{1'b0, 10'd0, 12'sd0, 1'b0}},
        '{'{OP_ARM, 16'h0000, 16'h0000, 16'h0000, 8'h01}, 1'b1, '{1'b0, 10'd0, 12'sd0, 1'b1}},
        '{'{OP_BLOCK_END, 16'h0000, 16'h0000, 16'h0000, 8'h00}, 1'b1, '{1'b0, 10'd0, 12'sd0, 1'b0}},
        // alternating bit patterns, scored by the model
        '{'{OP_SAMPLE, 16'hAAAA, 16'h5555, 16'h1234, 8'hAA}, 1'b0, '{1'b0, 10'd0, 12'sd0, 1'b0}},
        '{'{OP_SAMPLE, 16'h5555, 16'hAAAA, 16'h7FFF, 8'h55}, 1'b0, '{1'b0, 10'd0, 12'sd0, 1'b0}}
    };

    // register settings per random phase; entry 5 is drawn at start
    logic [10:0] phase_tp [N_PHASES] = '{11'd1024, 11'd1, 11'd0, 11'd2047,
                                         11'd2047, 11'd0, 11'd16, 11'd1024};
    logic [10:0] phase_sh [N_PHASES] = '{11'd512, 11'd1024, 11'd0, 11'd2047,
                                         11'd2047, 11'd0, 11'd1024, 11'd1};

    xy_pen_trace_capture_unit #(
        .MAX_POINTS(MAX_POINTS)
    ) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .sample_valid(sample_valid),
        .sample_stall(sample_stall),
        .sample      (sample),
        .trace_valid (trace_valid),
        .trace_stall (trace_stall),
        .trace       (trace),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // run limit
    initial
    begin
        #10_000_000;
        $display("xy_pen_trace_capture_unit test failed");
        $finish;
    end

    // trace word the unit should produce for one sample word; advances model state
    function automatic xpt_pkg::trace_word_t predict_trace_word(
        input xpt_pkg::sample_word_t w);
        xpt_pkg::trace_word_t res;
        logic [26:0] xprod;
        logic [26:0] yprod;
        logic [9:0]  col;
        int          h;
        int          tv;
        res = '0;
        case (w.opcode)
            OP_SAMPLE:
            begin
                xprod = w.x_sample * tp_reg;
                yprod = w.y_sample * sh_reg;
                col = (xprod[26:16] > 11'd1023) ? 10'd1023 : xprod[25:16];
                h = int'(sh_reg) - int'(yprod[26:16]);
                if (col < xpt_pkg::RETRACE_LIMIT)
                    last_col = '0;
                if (col > last_col && !(w.z_sample > xpt_pkg::PEN_UP_THRESHOLD))
                begin
                    if (blocks_left != 0)
                        offset_store[col] = 11'(int'(sh_reg >> 1) - h);
                    tv = h + offset_store[col];
                    if (tv > 2047)
                        tv = 2047;
                    else if (tv < -2048)
                        tv = -2048;
                    res.write_valid = 1'b1;
                    res.column = col;
                    res.trace_value = tv[11:0];
                    last_col = col;
                end
            end
            OP_BLOCK_END:
            begin
                if (blocks_left != 0)
                    blocks_left--;
            end
            OP_ARM:
                blocks_left = w.arm_count;
            default:
                ;
        endcase
        res.normalizing = (blocks_left != 0);
        return res;
    endfunction

    function automatic xpt_pkg::sample_word_t make_word(
        input logic [1:0] op, input logic [15:0] xv, input logic [15:0] yv,
        input logic [15:0] zv, input logic [7:0] arm);
        xpt_pkg::sample_word_t w;
        w.opcode    = op;
        w.x_sample  = xv;
        w.y_sample  = yv;
        w.z_sample  = zv;
        w.arm_count = arm;
        return w;
    endfunction

    // sender idle length: mostly none or short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (burst_mode || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // pen mostly down, threshold edges included
    function automatic logic [15:0] pick_z();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return 16'($urandom_range(0, 32767));
        if (r < 85)
            return 16'd32768;
        if (r < 90)
            return 16'd32769;
        return 16'($urandom_range(32769, 65535));
    endfunction

    // offer one word at a falling edge, hold it until taken; called and returns at a falling edge
    task automatic push_word(input xpt_pkg::sample_word_t w, input bit typed = 1'b0,
                             input xpt_pkg::trace_word_t fixed = '0);
        int gap;
        xpt_pkg::trace_word_t want;
        gap = pick_gap();
        if (gap > 0)
        begin
            sample_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        sample_valid <= 1'b1;
        sample <= w;
        do
            @(posedge clk);
        while (sample_stall);
        want = predict_trace_word(w);
        trace_q.push_back(typed ? fixed : want);
        words_sent++;
        @(negedge clk);
    endtask

    // let every outstanding trace word arrive, then a short settle
    task automatic drain_traces();
        sample_valid <= 1'b0;
        while (trace_q.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // register writes while the unit is idle
    task automatic set_config(input logic [10:0] tp, input logic [10:0] sh, input bit poke_unused);
        logic [1:0]  idx [3];
        logic [10:0] dat [3];
        int          n;
        idx[0] = REG_TRACE_POINTS;
        dat[0] = tp;
        idx[1] = REG_SCREEN_HEIGHT;
        dat[1] = sh;
        idx[2] = REG_UNUSED;
        dat[2] = 11'($urandom_range(0, 2047));
        n = poke_unused ? 3 : 2;
        cfg_valid <= 1'b1;
        for (int i = 0; i < n; i++)
        begin
            cfg_index <= idx[i];
            cfg_data <= dat[i];
            do
                @(posedge clk);
            while (!cfg_ready);
            if (idx[i] == REG_TRACE_POINTS)
                tp_reg = dat[i];
            else if (idx[i] == REG_SCREEN_HEIGHT)
                sh_reg = dat[i];
            @(negedge clk);
        end
        cfg_valid <= 1'b0;
    endtask

    // one plotter pass: optional arm, mostly rising x with random y and pen, then block end
    task automatic run_sweep();
        int n;
        int xv;
        if ($urandom_range(0, 1) == 0)
            push_word(make_word(OP_ARM, 16'($urandom), 16'($urandom), 16'($urandom),
                                ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 6))
                                                            : 8'($urandom_range(0, 255))));
        n = $urandom_range(3, 40);
        xv = $urandom_range(0, 1500);
        burst_mode = ($urandom_range(0, 4) == 0);
        for (int i = 0; i < n; i++)
        begin
            push_word(make_word(OP_SAMPLE, xv[15:0], 16'($urandom), pick_z(), 8'($urandom)));
            xv += $urandom_range(1, 131072 / n);
            if (xv > 65535)
                xv = 65535;
            if ($urandom_range(0, 30) == 0)
                xv = $urandom_range(0, 1500);
        end
        push_word(make_word(OP_BLOCK_END, 16'($urandom), 16'($urandom), 16'($urandom),
                            8'($urandom)));
        burst_mode = 1'b0;
    endtask

    // stray word of any opcode with fully random fields
    task automatic push_noise();
        int r;
        logic [1:0] op;
        r = $urandom_range(0, 99);
        if (r < 40)
            op = OP_SAMPLE;
        else if (r < 70)
            op = OP_BLOCK_END;
        else if (r < 85)
            op = OP_ARM;
        else
            op = OP_UNUSED;
        push_word(make_word(op, 16'($urandom), 16'($urandom), 16'($urandom), 8'($urandom)));
    endtask

    // receiver stall: short bursts, occasional long holds, long clear stretches
    initial
    begin
        int hold;
        trace_stall = 1'b0;
        hold = 0;
        forever
        begin
            @(negedge clk);
            if (hold > 0)
                hold--;
            else if (trace_stall)
            begin
                trace_stall <= 1'b0;
                hold = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 6)
                                                    : $urandom_range(20, 100);
            end
            else
            begin
                trace_stall <= 1'b1;
                hold = ($urandom_range(0, 99) < 90) ? $urandom_range(0, 2)
                                                    : $urandom_range(10, 40);
            end
        end
    end

    // score each accepted trace word against the oldest expectation
    always @(posedge clk)
    begin
        xpt_pkg::trace_word_t want;
        if (rst_n && trace_valid && !trace_stall)
        begin
            if (trace_q.size() == 0)
            begin
                fault_count++;
                if (fault_count <= 10)
                    $display("unexpected trace word: wv=%0b col=%0d val=%0d nrm=%0b",
                             trace.write_valid, trace.column, trace.trace_value,
                             trace.normalizing);
            end
            else
            begin
                want = trace_q.pop_front();
                if (trace.write_valid !== want.write_valid || trace.column !== want.column ||
                    trace.trace_value !== want.trace_value ||
                    trace.normalizing !== want.normalizing)
                begin
                    fault_count++;
                    if (fault_count <= 10)
                        $display("mismatch: expected %0b %0d %0d %0b, got %0b %0d %0d %0b",
                                 want.write_valid, want.column, want.trace_value,
                                 want.normalizing, trace.write_valid, trace.column,
                                 trace.trace_value, trace.normalizing);
                end
            end
        end
    end

    // main sequence
    initial
    begin
        rst_n        = 1'b0;
        sample_valid = 1'b0;
        sample       = '0;
        cfg_valid    = 1'b0;
        cfg_index    = REG_TRACE_POINTS;
        cfg_data     = '0;
        fault_count  = 0;
        words_sent   = 0;
        burst_mode   = 1'b0;
        tp_reg       = xpt_pkg::TRACE_POINTS_RST;
        sh_reg       = xpt_pkg::SCREEN_HEIGHT_RST;
        last_col     = '0;
        blocks_left  = '0;
        foreach (offset_store[i])
            offset_store[i] = '0;
        phase_tp[5] = 11'($urandom_range(1, 1024));
        phase_sh[5] = 11'($urandom_range(1, 1024));

        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        // directed table at reset register values
        for (int i = 0; i < DIR_ROWS; i++)
            push_word(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].fixed);

        // random phases, one register setting each
        for (int p = 0; p < N_PHASES; p++)
        begin
            drain_traces();
            set_config(phase_tp[p], phase_sh[p], p == 2);
            words_sent = 0;
            while (words_sent < PHASE_WORDS)
            begin
                if ($urandom_range(0, 3) == 0)
                    push_noise();
                else
                    run_sweep();
            end
        end

        drain_traces();
        repeat (8) @(posedge clk);
        if (fault_count == 0)
            $display("xy_pen_trace_capture_unit test passed");
        else
            $display("xy_pen_trace_capture_unit test failed");
        $finish;
    end

endmodule

// ===== files.f =====
sv/xpt_pkg.sv
sv/xpt_offset_ram.sv
sv/xy_pen_trace_capture_unit.sv
dv/tb.sv
